// ----- rtl/dda_pkg.sv -----
// dda_pkg: shared types for the dda line rasterizer
// mode codes and the command/status structs between controller and datapath
// no dependencies
`default_nettype none

package dda_pkg;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic step;
  } dda_cmd_t;

  typedef struct packed {
    logic active;
    logic div_last;
    logic out_free;
  } dda_status_t;

endpackage

`default_nettype wire

// ----- rtl/dda_ctrl.sv -----
// dda_ctrl: controller state machine of the dda line rasterizer
// sequences line load, divide iterations and pixel steps; uses dda_pkg
`default_nettype none

module dda_ctrl
  import dda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tuser,
  input  dda_status_t status,
  output dda_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == ST_IDLE) && status.out_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.step     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode_t'(s_tuser) == MODE_LOAD) begin
            cmd.load   = 1'b1;
            state_next = ST_DIV;
          end else begin
            cmd.step = status.active;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.div_step, cmd.step}))
    else $error("controller issued overlapping commands");

  a_load_starts_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_DIV)
    else $error("load did not start the divide");

  a_no_accept_in_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> !s_tready)
    else $error("input taken while dividing");

endmodule

`default_nettype wire

// ----- rtl/dda_datapath.sv -----
// dda_datapath: accumulators, restoring divider and output register
// driven by dda_ctrl commands; uses dda_pkg
`default_nettype none

module dda_datapath
  import dda_pkg::*;
#(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dda_cmd_t              cmd,
  output dda_status_t           status,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last_pixel
);

  localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam int Q_W   = FRAC_BITS + 1;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  function automatic logic [ACC_W-1:0] start_pos(input logic [COORD_BITS-1:0] s,
                                                 input logic neg,
                                                 input logic moving);
    logic [ACC_W-1:0] base;
    base = {1'b0, s, {FRAC_BITS{1'b0}}};
    if (!moving) begin
      return base;
    end
    return neg ? base - HALF : base + HALF;
  endfunction

  logic [ACC_W-1:0]      acc_x, acc_y, inc_x, inc_y;
  logic [ACC_W-1:0]      acc_x_next, acc_y_next;
  logic [COORD_BITS-1:0] steps_left, len;
  logic [COORD_BITS-1:0] rem_x, rem_y, rem_x_next, rem_y_next;
  logic [Q_W-1:0]        q_x, q_y, q_x_next, q_y_next;
  logic                  neg_x, neg_y;
  logic [CNT_W-1:0]      div_cnt;

  logic                  neg_x_in, neg_y_in;
  logic [COORD_BITS-1:0] mag_x_in, mag_y_in, len_in;
  logic [COORD_BITS:0]   trial_x, trial_y, len_ext;
  logic                  ge_x, ge_y;

  // load setup
  assign neg_x_in = end_x < start_x;
  assign neg_y_in = end_y < start_y;
  assign mag_x_in = neg_x_in ? start_x - end_x : end_x - start_x;
  assign mag_y_in = neg_y_in ? start_y - end_y : end_y - start_y;
  assign len_in   = (mag_x_in > mag_y_in) ? mag_x_in : mag_y_in;

  // one restoring divide step per axis
  assign len_ext    = {1'b0, len};
  assign trial_x    = (div_cnt == '0) ? {1'b0, rem_x} : {rem_x, 1'b0};
  assign trial_y    = (div_cnt == '0) ? {1'b0, rem_y} : {rem_y, 1'b0};
  assign ge_x       = (trial_x != '0) && (trial_x >= len_ext);
  assign ge_y       = (trial_y != '0) && (trial_y >= len_ext);
  assign rem_x_next = ge_x ? COORD_BITS'(trial_x - len_ext) : COORD_BITS'(trial_x);
  assign rem_y_next = ge_y ? COORD_BITS'(trial_y - len_ext) : COORD_BITS'(trial_y);
  assign q_x_next   = {q_x[FRAC_BITS-1:0], ge_x};
  assign q_y_next   = {q_y[FRAC_BITS-1:0], ge_y};

  assign acc_x_next = acc_x + inc_x;
  assign acc_y_next = acc_y + inc_y;

  assign status.active   = steps_left != '0;
  assign status.div_last = div_cnt == CNT_W'(FRAC_BITS);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        steps_left <= len_in;
      end else if (cmd.step) begin
        steps_left <= steps_left - COORD_BITS'(1);
      end
      if (cmd.step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_x   <= start_pos(start_x, neg_x_in, mag_x_in != '0);
      acc_y   <= start_pos(start_y, neg_y_in, mag_y_in != '0);
      neg_x   <= neg_x_in;
      neg_y   <= neg_y_in;
      rem_x   <= mag_x_in;
      rem_y   <= mag_y_in;
      len     <= len_in;
      q_x     <= '0;
      q_y     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem_x   <= rem_x_next;
      rem_y   <= rem_y_next;
      q_x     <= q_x_next;
      q_y     <= q_y_next;
      div_cnt <= div_cnt + CNT_W'(1);
      if (status.div_last) begin
        inc_x <= neg_x ? ACC_W'(0) - ACC_W'(q_x_next) : ACC_W'(q_x_next);
        inc_y <= neg_y ? ACC_W'(0) - ACC_W'(q_y_next) : ACC_W'(q_y_next);
      end
    end else if (cmd.step) begin
      acc_x      <= acc_x_next;
      acc_y      <= acc_y_next;
      pixel_x    <= acc_x_next[FRAC_BITS +: COORD_BITS];
      pixel_y    <= acc_y_next[FRAC_BITS +: COORD_BITS];
      last_pixel <= steps_left == COORD_BITS'(1);
    end
  end

  a_step_needs_pixels: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> steps_left != '0)
    else $error("step issued with no pixels left");

  a_step_fills_output: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> out_valid)
    else $error("step did not produce an output transfer");

  a_step_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> status.out_free)
    else $error("step would overwrite a pending pixel");

endmodule

`default_nettype wire

// ----- rtl/dda_line_rasterizer.sv -----
// dda_line_rasterizer: top level of the dda line rasterizer
// instantiates dda_ctrl and dda_datapath; uses dda_pkg
//
// input stream: tuser is the mode (0 load a line, 1 next pixel), tdata carries
// start_x, start_y, end_x, end_y. a load produces no output transfer; after
// the accept, restoring dividers, one per axis with a shared divisor, form
// both axis increments of FRAC_BITS+1 quotient bits; tready stays low
// during the divide. a step's pixel is in the output register the cycle
// after the transfer; steps may follow back to back at one per cycle
// while the receiver is ready. a step with no pixels left is consumed and
// produces nothing; a zero-length line produces no pixels. tlast marks the
// final pixel of a line. a new load replaces any line in progress.
// when the receiver stalls the pending pixel is held and input tready drops
// until it is taken. reset clears the pending output, the pixel count and
// the controller; the block is ready the first cycle after reset.
`default_nettype none

module dda_line_rasterizer
  import dda_pkg::*;
#(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // start_x, start_y, end_x, end_y, zero fill
  input  logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // mode
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // pixel_x, pixel_y, zero fill
  output logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  output logic m_tlast
);

  localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8;

  dda_cmd_t              cmd;
  dda_status_t           status;
  logic [COORD_BITS-1:0] pixel_x, pixel_y;

  dda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  dda_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .start_x    (s_tdata[0 +: COORD_BITS]),
    .start_y    (s_tdata[COORD_BITS +: COORD_BITS]),
    .end_x      (s_tdata[2 * COORD_BITS +: COORD_BITS]),
    .end_y      (s_tdata[3 * COORD_BITS +: COORD_BITS]),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (m_tlast)
  );

  assign m_tdata = OUT_W'({pixel_y, pixel_x});

endmodule

`default_nettype wire
